// ----- rtl/core/rrjs_pkg.sv -----
// Shared types and codes for the round-robin job scheduler core.
// No dependencies.
package rrjs_pkg;

    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_ORDER     = 3'd2,
        STATUS_ZERO_EXEC = 3'd3,
        STATUS_IDLE      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEND,
        ST_PRE,
        ST_READ,
        ST_RUN,
        ST_TA,
        ST_WT,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arr;
        logic [15:0] exe;
    } pend_entry_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arr;
        logic [15:0] exe;
        logic [15:0] rem;
    } rdy_entry_t;

    localparam logic [39:0] SUM_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

// ----- rtl/core/round_robin_job_scheduler_core.sv -----
// Round-robin time-slice scheduler core: pending and ready queues in two
// registered-read memories, dispatch sequencer and running totals.
// Depends on rrjs_pkg.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  request  | start, busy               | func, job_id, arrival_time, exec_time
//  config   | cfg_valid, cfg_ready      | cfg_data (time slice)
//  result   | result_valid (strobe)     | status ... total_turnaround
//
// An add request completes in its accept cycle; the result strobes the next.
// A dispatch moves the N arrived jobs, one per cycle, through the pending
// memory port into the ready memory; a preempted or empty result follows the
// run state, a completed one the turnaround, wait and sum states.
// Reset clears pointers, counts, time and totals; memories are not cleared.
// The receiver cannot stall; each result is shown for one cycle only.
module round_robin_job_scheduler_core
    import rrjs_pkg::*;
#(
    parameter int MAX_JOBS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  job_id,
    input  logic [15:0] arrival_time,
    input  logic [15:0] exec_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [7:0]  run_job_id,
    output logic [15:0] ran_time,
    output logic        finished,
    output logic [31:0] finish_time,
    output logic [31:0] wait_time,
    output logic [31:0] turnaround_time,
    output logic [15:0] total_finished,
    output logic [39:0] total_wait,
    output logic [39:0] total_turnaround
);

    localparam int PW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(MAX_JOBS - 1);
    localparam logic [CW+1:0] JOBS_LIM = (CW+2)'(MAX_JOBS);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // memories
    pend_entry_t pend_mem [MAX_JOBS];
    rdy_entry_t  rdy_mem  [MAX_JOBS];
    pend_entry_t pend_rd_reg;
    rdy_entry_t  rdy_rd_reg;

    logic        pend_we;
    logic [PW-1:0] pend_waddr;
    pend_entry_t pend_wdata;
    logic        rdy_we;
    logic [PW-1:0] rdy_waddr;
    rdy_entry_t  rdy_wdata;

    state_t state_reg, state_next;

    logic [PW-1:0] pend_head_reg, pend_head_next, pend_tail_reg, pend_tail_next;
    logic [PW-1:0] rdy_head_reg, rdy_head_next, rdy_tail_reg, rdy_tail_next;
    logic [CW-1:0] pend_cnt_reg, pend_cnt_next, rdy_cnt_reg, rdy_cnt_next;

    rdy_entry_t pre_job_reg, pre_job_next;
    logic       pre_valid_reg, pre_valid_next;

    logic [31:0] cur_time_reg, cur_time_next;
    logic [15:0] last_arr_reg, last_arr_next;
    logic [15:0] fin_cnt_reg, fin_cnt_next;
    logic [39:0] wait_sum_reg, wait_sum_next;
    logic [39:0] ta_sum_reg, ta_sum_next;
    logic [15:0] slice_reg, slice_next;

    // job being run
    logic [15:0] job_arr_reg, job_arr_next;
    logic [15:0] job_exe_reg, job_exe_next;

    logic        res_valid_reg, res_valid_next;
    status_t     res_status_reg, res_status_next;
    logic [7:0]  res_id_reg, res_id_next;
    logic [15:0] res_ran_reg, res_ran_next;
    logic        res_fin_reg, res_fin_next;
    logic [31:0] res_wait_reg, res_wait_next;
    logic [31:0] res_ta_reg, res_ta_next;

    logic        accept;
    logic [CW+1:0] jobs_inside;
    logic        pend_arrived;
    logic [15:0] slice_eff;
    logic [15:0] run_len;
    logic [32:0] time_sum;
    logic [15:0] rem_left;
    logic [40:0] wsum_wide;
    logic [40:0] tsum_wide;

    assign accept       = start && (state_reg == ST_IDLE);
    assign jobs_inside  = (CW+2)'(pend_cnt_reg) + (CW+2)'(rdy_cnt_reg)
                        + (CW+2)'(pre_valid_reg);
    assign pend_arrived = (pend_cnt_reg != '0) && ({16'd0, pend_rd_reg.arr} <= cur_time_reg);
    assign slice_eff    = (slice_reg == 16'd0) ? 16'd1 : slice_reg;
    assign run_len      = (rdy_rd_reg.rem < slice_eff) ? rdy_rd_reg.rem : slice_eff;
    assign time_sum     = {1'b0, cur_time_reg} + {17'd0, run_len};
    assign rem_left     = rdy_rd_reg.rem - run_len;
    assign wsum_wide    = {1'b0, wait_sum_reg} + {9'd0, res_wait_reg};
    assign tsum_wide    = {1'b0, ta_sum_reg} + {9'd0, res_ta_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_DISPATCH)
                    state_next = ST_PEND;
            end
            ST_PEND:
            begin
                if (!pend_arrived)
                    state_next = ST_PRE;
            end
            ST_PRE:  state_next = ST_READ;
            ST_READ: state_next = ST_RUN;
            ST_RUN:
            begin
                if (rdy_cnt_reg != '0 && rem_left == 16'd0)
                    state_next = ST_TA;
                else
                    state_next = ST_IDLE;
            end
            ST_TA:   state_next = ST_WT;
            ST_WT:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        pend_head_next  = pend_head_reg;
        pend_tail_next  = pend_tail_reg;
        pend_cnt_next   = pend_cnt_reg;
        rdy_head_next   = rdy_head_reg;
        rdy_tail_next   = rdy_tail_reg;
        rdy_cnt_next    = rdy_cnt_reg;
        pre_job_next    = pre_job_reg;
        pre_valid_next  = pre_valid_reg;
        cur_time_next   = cur_time_reg;
        last_arr_next   = last_arr_reg;
        fin_cnt_next    = fin_cnt_reg;
        wait_sum_next   = wait_sum_reg;
        ta_sum_next     = ta_sum_reg;
        slice_next      = slice_reg;
        job_arr_next    = job_arr_reg;
        job_exe_next    = job_exe_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_ran_next    = res_ran_reg;
        res_fin_next    = res_fin_reg;
        res_wait_next   = res_wait_reg;
        res_ta_next     = res_ta_reg;
        pend_we         = 1'b0;
        pend_waddr      = pend_tail_reg;
        pend_wdata      = '{id: job_id, arr: arrival_time, exe: exec_time};
        rdy_we          = 1'b0;
        rdy_waddr       = rdy_tail_reg;
        rdy_wdata       = '{id: pend_rd_reg.id, arr: pend_rd_reg.arr,
                            exe: pend_rd_reg.exe, rem: pend_rd_reg.exe};

        if (cfg_valid && cfg_ready)
            slice_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_ADD)
                begin
                    res_valid_next = 1'b1;
                    res_id_next    = '0;
                    res_ran_next   = '0;
                    res_fin_next   = 1'b0;
                    res_wait_next  = '0;
                    res_ta_next    = '0;
                    if (jobs_inside >= JOBS_LIM)
                        res_status_next = STATUS_FULL;
                    else if (arrival_time < last_arr_reg)
                        res_status_next = STATUS_ORDER;
                    else if (exec_time == 16'd0)
                        res_status_next = STATUS_ZERO_EXEC;
                    else
                    begin
                        res_status_next = STATUS_OK;
                        pend_we         = 1'b1;
                        pend_tail_next  = ptr_inc(pend_tail_reg);
                        pend_cnt_next   = pend_cnt_reg + 1'b1;
                        last_arr_next   = arrival_time;
                    end
                end
            end
            ST_PEND:
            begin
                if (pend_arrived)
                begin
                    rdy_we         = 1'b1;
                    rdy_tail_next  = ptr_inc(rdy_tail_reg);
                    rdy_cnt_next   = rdy_cnt_reg + 1'b1;
                    pend_head_next = ptr_inc(pend_head_reg);
                    pend_cnt_next  = pend_cnt_reg - 1'b1;
                end
            end
            ST_PRE:
            begin
                if (pre_valid_reg)
                begin
                    rdy_we         = 1'b1;
                    rdy_wdata      = pre_job_reg;
                    rdy_tail_next  = ptr_inc(rdy_tail_reg);
                    rdy_cnt_next   = rdy_cnt_reg + 1'b1;
                    pre_valid_next = 1'b0;
                end
                else if (rdy_cnt_reg == '0 && pend_cnt_reg != '0)
                begin
                    // nothing ready: jump ahead to the next arrival
                    rdy_we         = 1'b1;
                    rdy_tail_next  = ptr_inc(rdy_tail_reg);
                    rdy_cnt_next   = rdy_cnt_reg + 1'b1;
                    pend_head_next = ptr_inc(pend_head_reg);
                    pend_cnt_next  = pend_cnt_reg - 1'b1;
                    if ({16'd0, pend_rd_reg.arr} > cur_time_reg)
                        cur_time_next = {16'd0, pend_rd_reg.arr};
                end
            end
            ST_READ:
            begin
            end
            ST_RUN:
            begin
                res_fin_next  = 1'b0;
                res_wait_next = '0;
                res_ta_next   = '0;
                if (rdy_cnt_reg == '0)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STATUS_IDLE;
                    res_id_next     = '0;
                    res_ran_next    = '0;
                end
                else
                begin
                    res_status_next = STATUS_OK;
                    res_id_next     = rdy_rd_reg.id;
                    res_ran_next    = run_len;
                    rdy_head_next   = ptr_inc(rdy_head_reg);
                    rdy_cnt_next    = rdy_cnt_reg - 1'b1;
                    cur_time_next   = time_sum[32] ? TIME_MAX : time_sum[31:0];
                    job_arr_next    = rdy_rd_reg.arr;
                    job_exe_next    = rdy_rd_reg.exe;
                    if (rem_left != 16'd0)
                    begin
                        res_valid_next = 1'b1;
                        pre_valid_next = 1'b1;
                        pre_job_next   = '{id: rdy_rd_reg.id, arr: rdy_rd_reg.arr,
                                           exe: rdy_rd_reg.exe, rem: rem_left};
                    end
                end
            end
            ST_TA:
            begin
                res_ta_next = (cur_time_reg > {16'd0, job_arr_reg})
                            ? cur_time_reg - {16'd0, job_arr_reg} : '0;
            end
            ST_WT:
            begin
                res_wait_next = (res_ta_reg > {16'd0, job_exe_reg})
                              ? res_ta_reg - {16'd0, job_exe_reg} : '0;
                ta_sum_next   = tsum_wide[40] ? SUM_MAX : tsum_wide[39:0];
            end
            ST_SUM:
            begin
                res_valid_next = 1'b1;
                res_fin_next   = 1'b1;
                wait_sum_next  = wsum_wide[40] ? SUM_MAX : wsum_wide[39:0];
                if (fin_cnt_reg != COUNT_MAX)
                    fin_cnt_next = fin_cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy            = (state_reg != ST_IDLE);
        cfg_ready       = 1'b1;
        result_valid    = res_valid_reg;
        status          = res_status_reg;
        run_job_id      = res_id_reg;
        ran_time        = res_ran_reg;
        finished        = res_fin_reg;
        finish_time     = cur_time_reg;
        wait_time       = res_wait_reg;
        turnaround_time = res_ta_reg;
        total_finished  = fin_cnt_reg;
        total_wait      = wait_sum_reg;
        total_turnaround = ta_sum_reg;
    end

    // pending memory: read follows the next head so the read register holds the new head right after a pop
    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[pend_waddr] <= pend_wdata;
        pend_rd_reg <= pend_mem[pend_head_next];
    end

    // ready memory: writes never happen in the cycle before its data is used
    always_ff @(posedge clk)
    begin
        if (rdy_we)
            rdy_mem[rdy_waddr] <= rdy_wdata;
        rdy_rd_reg <= rdy_mem[rdy_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_head_reg  <= '0;
            pend_tail_reg  <= '0;
            pend_cnt_reg   <= '0;
            rdy_head_reg   <= '0;
            rdy_tail_reg   <= '0;
            rdy_cnt_reg    <= '0;
            pre_valid_reg  <= 1'b0;
            cur_time_reg   <= '0;
            last_arr_reg   <= '0;
            fin_cnt_reg    <= '0;
            wait_sum_reg   <= '0;
            ta_sum_reg     <= '0;
            slice_reg      <= 16'd2;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_head_reg  <= pend_head_next;
            pend_tail_reg  <= pend_tail_next;
            pend_cnt_reg   <= pend_cnt_next;
            rdy_head_reg   <= rdy_head_next;
            rdy_tail_reg   <= rdy_tail_next;
            rdy_cnt_reg    <= rdy_cnt_next;
            pre_valid_reg  <= pre_valid_next;
            cur_time_reg   <= cur_time_next;
            last_arr_reg   <= last_arr_next;
            fin_cnt_reg    <= fin_cnt_next;
            wait_sum_reg   <= wait_sum_next;
            ta_sum_reg     <= ta_sum_next;
            slice_reg      <= slice_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_job_reg    <= pre_job_next;
        job_arr_reg    <= job_arr_next;
        job_exe_reg    <= job_exe_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_ran_reg    <= res_ran_next;
        res_fin_reg    <= res_fin_next;
        res_wait_reg   <= res_wait_next;
        res_ta_reg     <= res_ta_next;
    end

endmodule
